[rtl/core/ttb_pkg.sv]
// Shared types, constants and codes of the token budget batcher.
package ttb_pkg;

  localparam int MAX_BATCH = 32;
  localparam int NCELL     = MAX_BATCH + 1;
  localparam int CNT_W     = $clog2(NCELL + 1);
  localparam int IDX_W     = 24;
  localparam int LEN_W     = 16;
  localparam int BUD_W     = 22;
  localparam int LIM_W     = 6;
  localparam int TOK_W     = CNT_W + 1 + LEN_W;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOKEN_BUDGET   = 3'd0,
    REG_SENTENCE_LIMIT = 3'd1,
    REG_SIZE_MULTIPLE  = 3'd2,
    REG_LENGTH_LIMIT   = 3'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_EMIT,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] sample_index;
    logic [LEN_W-1:0] source_length;
    logic [LEN_W-1:0] target_length;
    logic             final_sample;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] member_index;
    logic             batch_end;
    logic             run_last;
  } out_word_t;

  // Controls broadcast to every cell of the chain
  typedef struct packed {
    logic             shift;
    logic             load;
    logic             scan;
    logic [CNT_W-1:0] load_pos;
    logic [CNT_W-1:0] keep;
    logic [IDX_W-1:0] load_index;
    logic [LEN_W-1:0] load_length;
  } cell_ctrl_t;

endpackage

[rtl/core/ttb_cell.sv]
// One cell of the member chain: holds one member index and length.
module ttb_cell
  import ttb_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [CNT_W-1:0] pos,
  input  logic [IDX_W-1:0] nb_index,
  input  logic [LEN_W-1:0] nb_length,
  input  logic [LEN_W-1:0] mx_in,
  output logic [IDX_W-1:0] index_o,
  output logic [LEN_W-1:0] length_o,
  output logic [LEN_W-1:0] mx_o
);

  logic [IDX_W-1:0] index_r, index_nxt;
  logic [LEN_W-1:0] length_r, length_nxt;
  logic [LEN_W-1:0] mx_r, mx_nxt;
  logic [LEN_W-1:0] own_len;

  // Load the new word at its slot, or advance from the upper neighbour
  always_comb begin
    index_nxt  = index_r;
    length_nxt = length_r;
    if (ctrl.load && (ctrl.load_pos == pos)) begin
      index_nxt  = ctrl.load_index;
      length_nxt = ctrl.load_length;
    end else if (ctrl.shift) begin
      index_nxt  = nb_index;
      length_nxt = nb_length;
    end
  end

  // Pass the running maximum on towards the top of the chain
  always_comb begin
    own_len = (pos <= ctrl.keep) ? length_r : '0;
    mx_nxt  = mx_r;
    if (ctrl.scan) begin
      mx_nxt = (own_len > mx_in) ? own_len : mx_in;
    end
  end

  always_ff @(posedge clk) begin
    index_r  <= index_nxt;
    length_r <= length_nxt;
    mx_r     <= mx_nxt;
  end

  assign index_o  = index_r;
  assign length_o = length_r;
  assign mx_o     = mx_r;

endmodule

[rtl/core/token_budget_batcher.sv]
// Top level of the token budget batcher: control sequencer and member chain.
//
// Samples are taken one at a time and grouped into batches under a padded
// token budget. A sample that closes a batch passes through the remainder
// unit, which subtracts once per cycle; then the member chain shifts by
// one word per emitted member and the maximum is swept along the chain.
// A flush emits one word per open member. Results leave through a
// registered output; configuration writes are always taken and must only
// arrive while the block is idle.
module token_budget_batcher
  import ttb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BUD_W-1:0]     cfg_data
);

  state_t           state_r, state_nxt;
  logic [BUD_W-1:0] budget_r;
  logic [LIM_W-1:0] slimit_r, smult_r;
  logic [LEN_W-1:0] llimit_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] rmax_r, rmax_nxt;
  logic [TOK_W-1:0] tok_r, tok_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] mul_r, mul_nxt;
  logic [CNT_W-1:0] take_r, take_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             fin_r, fin_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic [LEN_W-1:0] len, new_max;
  logic [CNT_W-1:0] lim, down, last_k;
  logic             can_push, full, end_m;
  cell_ctrl_t       ctrl;

  logic [IDX_W-1:0] c_index [NCELL];
  logic [LEN_W-1:0] c_length[NCELL];
  logic [LEN_W-1:0] c_mx    [NCELL];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign can_push  = !out_valid_r || !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUD_W'(4096);
      slimit_r <= LIM_W'(32);
      smult_r  <= LIM_W'(1);
      llimit_r <= LEN_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TOKEN_BUDGET:   budget_r <= cfg_data;
        REG_SENTENCE_LIMIT: slimit_r <= cfg_data[LIM_W-1:0];
        REG_SIZE_MULTIPLE:  smult_r  <= cfg_data[LIM_W-1:0];
        REG_LENGTH_LIMIT:   llimit_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Member chain
  genvar g;
  generate
    for (g = 0; g < NCELL; g++) begin : g_cell
      logic [IDX_W-1:0] nb_i;
      logic [LEN_W-1:0] nb_l, mx_i;
      if (g == NCELL - 1) begin : g_top
        assign nb_i = '0;
        assign nb_l = '0;
      end else begin : g_mid
        assign nb_i = c_index[g+1];
        assign nb_l = c_length[g+1];
      end
      if (g == 0) begin : g_bot
        assign mx_i = '0;
      end else begin : g_up
        assign mx_i = c_mx[g-1];
      end
      ttb_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .pos       (CNT_W'(g)),
        .nb_index  (nb_i),
        .nb_length (nb_l),
        .mx_in     (mx_i),
        .index_o   (c_index[g]),
        .length_o  (c_length[g]),
        .mx_o      (c_mx[g])
      );
    end
  endgenerate

  // Sequencer
  always_comb begin
    len      = (in_word.source_length > in_word.target_length) ?
               in_word.source_length : in_word.target_length;
    new_max  = (len > rmax_r) ? len : rmax_r;
    lim      = ((slimit_r == '0) || (slimit_r > LIM_W'(MAX_BATCH))) ?
               CNT_W'(MAX_BATCH) : CNT_W'(slimit_r);
    full     = (cnt_r != '0) && ((cnt_r == lim) || (cnt_r >= CNT_W'(MAX_BATCH)) ||
               (tok_r > TOK_W'(budget_r)));
    down     = cnt_r - rem_r;
    last_k   = (state_r == ST_FLUSH) ? cnt_r : take_r;
    end_m    = (k_r + 1'b1) == last_k;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rmax_nxt      = rmax_r;
    tok_nxt       = tok_r;
    rem_nxt       = rem_r;
    mul_nxt       = mul_r;
    take_nxt      = take_r;
    k_nxt         = k_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;

    ctrl             = '0;
    ctrl.load_pos    = cnt_r;
    ctrl.keep        = cnt_r;
    ctrl.load_index  = in_word.sample_index;
    ctrl.load_length = len;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          fin_nxt = in_word.final_sample;
          k_nxt   = '0;
          if (len <= llimit_r) begin
            rmax_nxt  = new_max;
            ctrl.load = 1'b1;
            tok_nxt   = TOK_W'(cnt_r + 1'b1) * TOK_W'(new_max);
            state_nxt = ST_EVAL;
          end else if (in_word.final_sample && (cnt_r != '0)) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_EVAL: begin
        if (full) begin
          rem_nxt   = cnt_r;
          mul_nxt   = (smult_r == '0) ? CNT_W'(1) : CNT_W'(smult_r);
          state_nxt = ST_DIV;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = fin_r ? ST_FLUSH : ST_IDLE;
        end
      end
      // Remainder by repeated subtraction, one step a cycle
      ST_DIV: begin
        if (rem_r >= mul_r) begin
          rem_nxt = rem_r - mul_r;
        end else begin
          take_nxt  = (down > rem_r) ? down : rem_r;
          k_nxt     = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT, ST_FLUSH: begin
        if (can_push) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.member_index = c_index[0];
          out_word_nxt.batch_end    = end_m;
          out_word_nxt.run_last     = end_m && ((state_r == ST_FLUSH) || !fin_r);
          ctrl.shift                = 1'b1;
          k_nxt                     = k_r + 1'b1;
          if (end_m) begin
            k_nxt = '0;
            if (state_r == ST_EMIT) begin
              cnt_nxt   = cnt_r - take_r;
              state_nxt = ST_SCAN;
            end else begin
              cnt_nxt   = '0;
              rmax_nxt  = '0;
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      // Sweep the maximum along the chain, then close the step
      ST_SCAN: begin
        if (k_r == CNT_W'(NCELL)) begin
          rmax_nxt  = c_mx[NCELL-1];
          cnt_nxt   = cnt_r + 1'b1;
          k_nxt     = '0;
          state_nxt = fin_r ? ST_FLUSH : ST_IDLE;
        end else begin
          ctrl.scan = 1'b1;
          k_nxt     = k_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rmax_r      <= '0;
      k_r         <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rmax_r      <= rmax_nxt;
      k_r         <= k_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r      <= tok_nxt;
    rem_r      <= rem_nxt;
    mul_r      <= mul_nxt;
    take_r     <= take_nxt;
    out_word_r <= out_word_nxt;
  end

  // The open batch never outgrows the chain
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BATCH))
    else $error("member count above chain capacity");

  // An emission always takes at least one member and no more than are open
  a_take_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ((take_r != '0) && (take_r <= cnt_r)))
    else $error("emission size out of range");

  // The last member of a batch emission is followed by the maximum sweep
  a_emit_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && can_push && end_m) |=> (state_r == ST_SCAN))
    else $error("maximum sweep skipped after emission");

  // A flush leaves an empty batch with no running maximum
  a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FLUSH) && can_push && end_m) |=> ((cnt_r == '0) && (rmax_r == '0)))
    else $error("flush left state behind");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the token budget batcher: directed and random sample streams.
module tb_top
  import ttb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_word;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BUD_W-1:0]     cfg_data;

  token_budget_batcher DUT (.*);

  // Predictor state and configuration
  logic [BUD_W-1:0] pred_budget;
  logic [LIM_W-1:0] pred_sent_limit;
  logic [LIM_W-1:0] pred_multiple;
  logic [LEN_W-1:0] pred_len_limit;
  logic [IDX_W-1:0] open_members [MAX_BATCH];
  logic [LEN_W-1:0] open_lengths [NCELL];
  int unsigned      open_count;
  logic [LEN_W-1:0] open_max;

  out_word_t expected_words [$];
  int        error_count;
  int        words_seen;
  int        batches_seen;
  int        items_sent;
  longint    cycle_count;
  bit        long_hold;
  int        hold_cycles;
  bit        calm;

  // Clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("FAIL token_budget_batcher");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Work out the words one sample causes
  task automatic predict_batches(input in_word_t s);
    logic [LEN_W-1:0] len;
    int unsigned      lim, m, cnt, take, down, rem, keep;
    logic [LEN_W-1:0] mx;
    longint unsigned  tokens;
    bit               full;
    int               n0;
    out_word_t        w;
    n0 = expected_words.size();
    len = (s.source_length > s.target_length) ? s.source_length : s.target_length;
    if (len <= pred_len_limit) begin
      lim = pred_sent_limit;
      if (lim == 0 || lim > MAX_BATCH) lim = MAX_BATCH;
      cnt = open_count;
      if (len > open_max) open_max = len;
      open_lengths[cnt] = len;
      tokens = longint'(cnt + 1) * longint'(open_max);
      full = cnt != 0 && (cnt == lim || cnt >= MAX_BATCH || tokens > pred_budget);
      if (full) begin
        m = (pred_multiple == 0) ? 1 : pred_multiple;
        down = cnt / m * m;
        rem = cnt % m;
        take = (down > rem) ? down : rem;
        keep = cnt - take;
        for (int i = 0; i < take; i++) begin
          w.member_index = open_members[i];
          w.batch_end = (i + 1 == take);
          w.run_last = 1'b0;
          expected_words.insert(expected_words.size(), w);
        end
        for (int i = 0; i < keep; i++) open_members[i] = open_members[take + i];
        mx = '0;
        for (int i = 0; i <= keep; i++) begin
          open_lengths[i] = open_lengths[take + i];
          if (open_lengths[i] > mx) mx = open_lengths[i];
        end
        open_max = mx;
        cnt = keep;
      end
      open_members[cnt] = s.sample_index;
      open_count = cnt + 1;
    end
    if (s.final_sample) begin
      for (int i = 0; i < open_count; i++) begin
        w.member_index = open_members[i];
        w.batch_end = (i + 1 == open_count);
        w.run_last = 1'b0;
        expected_words.insert(expected_words.size(), w);
      end
      open_count = 0;
      open_max = '0;
    end
    if (expected_words.size() > n0) expected_words[$].run_last = 1'b1;
  endtask

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (out_word.batch_end) batches_seen++;
      if (expected_words.size() == 0) begin
        report("unexpected word", out_word.member_index, 0);
      end else begin
        want = expected_words.pop_front();
        if (out_word.member_index !== want.member_index)
          report("member_index", out_word.member_index, want.member_index);
        if (out_word.batch_end !== want.batch_end)
          report("batch_end", out_word.batch_end, want.batch_end);
        if (out_word.run_last !== want.run_last)
          report("run_last", out_word.run_last, want.run_last);
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // Offer one word and hold it until taken; valid stays up for the next word
  task automatic send_sample(input in_word_t s);
    in_valid <= 1'b1;
    in_word <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_batches(s);
    items_sent++;
  endtask

  // Drop the input valid between bursts
  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  // Sender with bursts and gaps
  task automatic send_paced(input in_word_t s);
    if (!calm && $urandom_range(0, 4) == 0) begin
      stop_input();
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    send_sample(s);
  endtask

  task automatic wait_drained();
    stop_input();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [BUD_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (r)
      REG_TOKEN_BUDGET:   pred_budget = v;
      REG_SENTENCE_LIMIT: pred_sent_limit = v[LIM_W-1:0];
      REG_SIZE_MULTIPLE:  pred_multiple = v[LIM_W-1:0];
      REG_LENGTH_LIMIT:   pred_len_limit = v[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int bud, input int sl, input int sm, input int ll);
    write_reg(REG_TOKEN_BUDGET, BUD_W'(bud));
    write_reg(REG_SENTENCE_LIMIT, BUD_W'(sl));
    write_reg(REG_SIZE_MULTIPLE, BUD_W'(sm));
    write_reg(REG_LENGTH_LIMIT, BUD_W'(ll));
    cfg_valid <= 1'b0;
  endtask

  function automatic in_word_t make_sample(input int maxlen, input int fin_odds);
    in_word_t s;
    s.sample_index = IDX_W'($urandom);
    s.source_length = LEN_W'($urandom_range(0, maxlen));
    s.target_length = LEN_W'($urandom_range(0, maxlen));
    s.final_sample = ($urandom_range(0, fin_odds) == 0);
    return s;
  endfunction

  // Field extremes, drops with flush, empty flush, forced full at store depth
  task automatic test_directed();
    in_word_t s;
    configure(22'h3FFFFF, 0, 0, 16'hFFFF);
    s = '{24'hFFFFFF, 16'hFFFF, 16'h0000, 1'b0}; send_sample(s);
    s = '{24'h000000, 16'h0000, 16'hFFFF, 1'b1}; send_sample(s);
    s = '{24'h123456, 16'h0001, 16'h0002, 1'b1}; send_sample(s);
    s = '{24'h0000AA, 16'h0000, 16'h0000, 1'b1}; send_sample(s);
    s = '{24'h0000AB, 16'h0000, 16'h0000, 1'b1}; send_sample(s);
    for (int i = 0; i < 34; i++) send_sample(make_sample(3, 1000));
    s = '{24'h0000BB, 16'h0005, 16'h0005, 1'b1}; send_sample(s);
    wait_drained();
    configure(4096, 32, 1, 1024);
    s = '{24'hABCDEF, 16'd2000, 16'd3, 1'b1}; send_sample(s);
    s = '{24'h00CAFE, 16'd0, 16'd1025, 1'b0}; send_sample(s);
    s = '{24'h00CAFF, 16'd1024, 16'd0, 1'b1}; send_sample(s);
    wait_drained();
    configure(1, 3, 2, 0);
    for (int i = 0; i < 6; i++) send_sample(make_sample(1, 6));
    wait_drained();
  endtask

  // Random samples under one setting
  task automatic test_random(input int bud, input int sl, input int sm,
                             input int ll, input int maxlen, input int count);
    configure(bud, sl, sm, ll);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      send_paced(make_sample(maxlen, 15));
    end
    calm = 1'b0;
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering samples
  task automatic test_backpressure();
    configure(64, 4, 3, 100);
    long_hold = 1'b1;
    fork
      begin
        for (int i = 0; i < 30; i++) send_sample(make_sample(40, 20));
      end
      begin
        while (hold_cycles < 600) @(posedge clk);
        long_hold = 1'b0;
      end
    join
    long_hold = 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_TOKEN_BUDGET;
    cfg_data = '0;
    error_count = 0;
    words_seen = 0;
    batches_seen = 0;
    items_sent = 0;
    cycle_count = 0;
    long_hold = 1'b0;
    hold_cycles = 0;
    calm = 1'b0;
    pred_budget = 4096;
    pred_sent_limit = 32;
    pred_multiple = 1;
    pred_len_limit = 1024;
    open_count = 0;
    open_max = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(4096, 32, 1, 1024, 300, 40);
    test_random(200, 7, 3, 60, 70, 40);
    test_random(22'h3FFFFF, 63, 32, 16'hFFFF, 65535, 35);
    test_random(1000, 5, 4, 500, 600, 35);
    test_backpressure();
    $display("covered %0d samples, %0d words in %0d batches over eight settings",
             items_sent, words_seen, batches_seen);
    $display("including store-depth batches, drops, flushes and a long receiver hold-off");
    if (error_count == 0) begin
      $display("PASS token_budget_batcher");
    end else begin
      $display("FAIL token_budget_batcher");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/ttb_pkg.sv
rtl/core/ttb_cell.sv
rtl/core/token_budget_batcher.sv
dv/tb_top.sv
